// ===== src/hedf_pkg.sv =====
// shared types, constants, microcode encoding and helper functions for the half-edge flip core
package hedf_pkg;

    localparam int MAX_TRIANGLES = 4096;
    localparam int TABLE_DEPTH   = 3 * MAX_TRIANGLES;
    localparam int ENTRY_W       = 14;
    localparam int TRI_W         = 12;
    localparam int CNT_W         = 13;
    localparam int QUO_W         = 13;
    localparam int STEP_W        = 5;

    // x / 3 as (x * DIV3_MUL) >> DIV3_SHIFT, exact for every 14-bit x
    localparam int DIV3_MUL   = 21846;
    localparam int DIV3_SHIFT = 16;
    localparam int PROD_W     = ENTRY_W + 15;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_FLIP  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SELF  = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [ENTRY_W-1:0] entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [TRI_W-1:0]   flip_triangle;
        logic [1:0]         flip_slot;
    } t_in_item;

    typedef struct packed {
        logic [ENTRY_W-1:0] read_value;
        logic [1:0]         status;
    } t_out_item;

    typedef logic [STEP_W-1:0] t_step;

    // microprogram addresses
    localparam t_step S_IDLE = 5'd0;
    localparam t_step S_WR   = 5'd1;
    localparam t_step S_RD0  = 5'd2;
    localparam t_step S_RD1  = 5'd3;
    localparam t_step S_F0   = 5'd4;
    localparam t_step S_F1   = 5'd5;
    localparam t_step S_F2   = 5'd6;
    localparam t_step S_F3   = 5'd7;
    localparam t_step S_F4   = 5'd8;
    localparam t_step S_F5   = 5'd9;
    localparam t_step S_F6   = 5'd10;
    localparam t_step S_F7   = 5'd11;
    localparam t_step S_F8   = 5'd12;
    localparam t_step S_F9   = 5'd13;
    localparam t_step S_F10  = 5'd14;
    localparam t_step S_F11  = 5'd15;
    localparam t_step S_F12  = 5'd16;
    localparam t_step S_F13  = 5'd17;
    localparam t_step S_F14  = 5'd18;
    localparam t_step S_F15  = 5'd19;
    localparam t_step S_OUT  = 5'd20;

    typedef enum logic [2:0] {
        TS_NONE, TS_IDX, TS_AK, TS_B, TS_ORANGE, TS_ODEGEN
    } t_test;

    typedef enum logic [2:0] {
        CL_NONE, CL_ADDR, CL_DIVB, CL_REM, CL_NEXTB, CL_DIVO
    } t_calc;

    typedef enum logic [2:0] {
        CP_NONE, CP_HB, CP_O01, CP_O23, CP_RV
    } t_cap;

    typedef enum logic [1:0] {
        RA_IDX, RA_H, RA_HA1, RA_HB1
    } t_rda;

    typedef enum logic {
        RB_HA2, RB_HB2
    } t_rdb;

    typedef enum logic [2:0] {
        WR_NONE, WR_IDX_VAL, WR_H_O2, WR_O2_H, WR_HA1_HB1, WR_HB1_HA1, WR_HB_O0, WR_O0_HB
    } t_wr;

    typedef enum logic [1:0] {
        SQ_NEXT, SQ_GOTO, SQ_DISPATCH, SQ_EMIT
    } t_seq;

    typedef struct packed {
        t_test test;
        t_calc calc;
        t_cap  cap;
        logic  rd_en;
        t_rda  rda;
        t_rdb  rdb;
        t_wr   wr;
        t_seq  seq;
        t_step target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        test: TS_NONE, calc: CL_NONE, cap: CP_NONE, rd_en: 1'b0,
        rda: RA_IDX, rdb: RB_HA2, wr: WR_NONE, seq: SQ_NEXT, target: S_IDLE
    };

    function automatic logic [QUO_W-1:0] div3(input logic [ENTRY_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV3_MUL);
        return p[DIV3_SHIFT +: QUO_W];
    endfunction

    function automatic logic [1:0] slot_plus1(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] slot_plus2(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic t_step dispatch(input logic [1:0] func);
        case (func)
            FN_WRITE: return S_WR;
            FN_READ:  return S_RD0;
            FN_FLIP:  return S_F0;
            default:  return S_OUT;
        endcase
    endfunction

endpackage

// ===== src/hedf_rom.sv =====
// microprogram store: one control word per sequencer step
module hedf_rom (
    input  hedf_pkg::t_step  i_step,
    output hedf_pkg::t_uword o_word
);
    import hedf_pkg::*;

    always_comb begin
        o_word = UW_NOP;
        case (i_step)
            S_IDLE: begin
                o_word.seq = SQ_DISPATCH;
            end
            S_WR: begin
                o_word.test   = TS_IDX;
                o_word.wr     = WR_IDX_VAL;
                o_word.seq    = SQ_GOTO;
                o_word.target = S_OUT;
            end
            S_RD0: begin
                o_word.test  = TS_IDX;
                o_word.rd_en = 1'b1;
                o_word.rda   = RA_IDX;
            end
            S_RD1: begin
                o_word.cap    = CP_RV;
                o_word.seq    = SQ_GOTO;
                o_word.target = S_OUT;
            end
            S_F0: begin
                o_word.test = TS_AK;
                o_word.calc = CL_ADDR;
            end
            S_F1: begin
                o_word.rd_en = 1'b1;
                o_word.rda   = RA_H;
            end
            S_F2: begin
                o_word.cap   = CP_HB;
                o_word.rd_en = 1'b1;
                o_word.rda   = RA_HA1;
                o_word.rdb   = RB_HA2;
            end
            S_F3: begin
                o_word.cap  = CP_O01;
                o_word.calc = CL_DIVB;
            end
            S_F4: begin
                o_word.calc = CL_REM;
            end
            S_F5: begin
                o_word.test = TS_B;
                o_word.calc = CL_NEXTB;
            end
            S_F6: begin
                o_word.rd_en = 1'b1;
                o_word.rda   = RA_HB1;
                o_word.rdb   = RB_HB2;
            end
            S_F7: begin
                o_word.cap = CP_O23;
            end
            S_F8: begin
                o_word.calc = CL_DIVO;
            end
            S_F9: begin
                o_word.test = TS_ORANGE;
            end
            S_F10: begin
                o_word.test = TS_ODEGEN;
                o_word.wr   = WR_H_O2;
            end
            S_F11: begin
                o_word.wr = WR_O2_H;
            end
            S_F12: begin
                o_word.wr = WR_HA1_HB1;
            end
            S_F13: begin
                o_word.wr = WR_HB1_HA1;
            end
            S_F14: begin
                o_word.wr = WR_HB_O0;
            end
            S_F15: begin
                o_word.wr     = WR_O0_HB;
                o_word.seq    = SQ_GOTO;
                o_word.target = S_OUT;
            end
            S_OUT: begin
                o_word.seq = SQ_EMIT;
            end
            default: begin
                o_word.seq    = SQ_GOTO;
                o_word.target = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/hedf_dpath.sv =====
// datapath: opposite table memory, operand registers, divide-by-three and checks
module hedf_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hedf_pkg::t_uword    i_word,
    input  logic                i_accept,
    input  hedf_pkg::t_in_item  i_in,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_wdata,
    output logic                o_fail,
    output hedf_pkg::t_out_item o_result
);
    import hedf_pkg::*;

    logic [ENTRY_W-1:0] mem [0:TABLE_DEPTH-1];

    logic [CNT_W-1:0]   r_n;
    logic [ENTRY_W-1:0] r_idx, r_val;
    logic [TRI_W-1:0]   r_a;
    logic [1:0]         r_k;
    logic [ENTRY_W-1:0] r_h, r_ha1, r_ha2, r_hb, r_hb1, r_hb2;
    logic [QUO_W-1:0]   r_b;
    logic [1:0]         r_j;
    logic [ENTRY_W-1:0] r_o [4];
    logic [QUO_W-1:0]   r_q [4];
    logic [ENTRY_W-1:0] r_rv;
    logic [1:0]         r_status;
    logic [ENTRY_W-1:0] r_rda, r_rdb;

    logic [ENTRY_W-1:0] a_ext, b_ext, base_a, base_b, rem_diff;
    logic [CNT_W-1:0]   a_cnt;
    logic               fail;
    logic [1:0]         fail_code;
    logic               rd_en, we;
    logic [ENTRY_W-1:0] raddr_a, raddr_b, waddr, wdata;

    // 3a and 3b by shift and add
    assign a_ext    = ENTRY_W'(r_a);
    assign b_ext    = ENTRY_W'(r_b);
    assign base_a   = (a_ext << 1) + a_ext;
    assign base_b   = (b_ext << 1) + b_ext;
    assign rem_diff = r_hb - base_b;
    assign a_cnt    = CNT_W'(r_a);

    always_comb begin
        fail      = 1'b0;
        fail_code = ST_DONE;
        case (i_word.test)
            TS_IDX: begin
                if (r_idx >= ENTRY_W'(TABLE_DEPTH)) begin
                    fail      = 1'b1;
                    fail_code = ST_RANGE;
                end
            end
            TS_AK: begin
                if (a_cnt >= r_n || r_k > 2'd2) begin
                    fail      = 1'b1;
                    fail_code = ST_RANGE;
                end
            end
            TS_B: begin
                if (r_b >= r_n) begin
                    fail      = 1'b1;
                    fail_code = ST_RANGE;
                end else if (r_b == a_cnt) begin
                    fail      = 1'b1;
                    fail_code = ST_SELF;
                end
            end
            TS_ORANGE: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_q[i] >= r_n) begin
                        fail = 1'b1;
                    end
                end
                fail_code = ST_RANGE;
            end
            TS_ODEGEN: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_q[i] == a_cnt || r_q[i] == r_b) begin
                        fail = 1'b1;
                    end
                end
                fail_code = ST_DEGEN;
            end
            default: begin
                fail = 1'b0;
            end
        endcase
    end

    assign o_fail = fail;
    assign rd_en  = i_word.rd_en && !fail;
    assign we     = (i_word.wr != WR_NONE) && !fail;

    always_comb begin
        case (i_word.rda)
            RA_IDX:  raddr_a = r_idx;
            RA_H:    raddr_a = r_h;
            RA_HA1:  raddr_a = r_ha1;
            RA_HB1:  raddr_a = r_hb1;
            default: raddr_a = r_idx;
        endcase
        case (i_word.rdb)
            RB_HA2:  raddr_b = r_ha2;
            RB_HB2:  raddr_b = r_hb2;
            default: raddr_b = r_ha2;
        endcase
    end

    // rewiring order matters when pairs share an address
    always_comb begin
        case (i_word.wr)
            WR_IDX_VAL: begin waddr = r_idx;  wdata = r_val;  end
            WR_H_O2:    begin waddr = r_h;    wdata = r_o[2]; end
            WR_O2_H:    begin waddr = r_o[2]; wdata = r_h;    end
            WR_HA1_HB1: begin waddr = r_ha1;  wdata = r_hb1;  end
            WR_HB1_HA1: begin waddr = r_hb1;  wdata = r_ha1;  end
            WR_HB_O0:   begin waddr = r_hb;   wdata = r_o[0]; end
            WR_O0_HB:   begin waddr = r_o[0]; wdata = r_hb;   end
            default:    begin waddr = r_idx;  wdata = r_val;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rda <= mem[raddr_a];
            r_rdb <= mem[raddr_b];
        end
    end

    // count in use, clipped to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= CNT_W'(MAX_TRIANGLES);
        end else if (i_cfg_we) begin
            r_n <= (i_cfg_wdata > CNT_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES) : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_idx    <= i_in.entry_index;
            r_val    <= i_in.entry_value;
            r_a      <= i_in.flip_triangle;
            r_k      <= i_in.flip_slot;
            r_rv     <= '0;
            r_status <= (i_in.func inside {FN_WRITE, FN_READ, FN_FLIP}) ? ST_DONE : ST_RANGE;
        end else begin
            if (fail) begin
                r_status <= fail_code;
            end
            case (i_word.cap)
                CP_HB:  r_hb <= r_rda;
                CP_O01: begin
                    r_o[0] <= r_rda;
                    r_o[1] <= r_rdb;
                end
                CP_O23: begin
                    r_o[2] <= r_rda;
                    r_o[3] <= r_rdb;
                end
                CP_RV:  r_rv <= r_rda;
                default: begin
                end
            endcase
            case (i_word.calc)
                CL_ADDR: begin
                    r_h   <= base_a + ENTRY_W'(r_k);
                    r_ha1 <= base_a + ENTRY_W'(slot_plus1(r_k));
                    r_ha2 <= base_a + ENTRY_W'(slot_plus2(r_k));
                end
                CL_DIVB: r_b <= div3(r_hb);
                CL_REM:  r_j <= rem_diff[1:0];
                CL_NEXTB: begin
                    r_hb1 <= base_b + ENTRY_W'(slot_plus1(r_j));
                    r_hb2 <= base_b + ENTRY_W'(slot_plus2(r_j));
                end
                CL_DIVO: begin
                    for (int i = 0; i < 4; i++) begin
                        r_q[i] <= div3(r_o[i]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = '{read_value: r_rv, status: r_status};

endmodule

// ===== src/half_edge_diagonal_flip_core.sv =====
// top level: microprogram sequencer, result register and datapath hookup
// Half-edge opposite table with write, read and diagonal flip commands.
// Input channel: i_valid / o_stall carries one t_in_item beat; a beat is taken
// at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carries one t_out_item beat per input beat,
// in order. read_value is nonzero only for a successful read.
// Configuration: i_cfg_we with i_cfg_wdata sets the triangle count; write it
// only while no command is in flight.
// A full flip runs 16 microprogram steps: five table reads over the two read
// ports, the divide-by-three steps, the checks, then six table writes through
// the single write port. A failed check ends a flip early at the output step.
// Each command returns to the idle step before the next beat is taken.
// The result register lets a new beat be taken while a result is stalled;
// a later result then waits in the output step until the register frees up.
// Reset (synchronous, active low) returns the sequencer to idle, drops o_valid
// and sets the count to the full table. Table contents are not cleared.
module half_edge_diagonal_flip_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hedf_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output hedf_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_wdata
);
    import hedf_pkg::*;

    t_step     r_step, n_step;
    t_uword    word;
    logic      accept;
    logic      fail;
    logic      emit;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item result;

    // control word for the current step
    hedf_rom u_rom (
        .i_step (r_step),
        .o_word (word)
    );

    hedf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (word),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail      (fail),
        .o_result    (result)
    );

    // new beats only in the idle step
    assign o_stall = !i_rst_n || (r_step != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // result register free, or being drained this cycle
    assign emit = (word.seq == SQ_EMIT) && (!r_out_valid || !i_stall);

    // step counter with conditional jumps; any failed check goes to the output step
    always_comb begin
        n_step = r_step;
        if (fail) begin
            n_step = S_OUT;
        end else begin
            case (word.seq)
                SQ_NEXT:     n_step = r_step + STEP_W'(1);
                SQ_GOTO:     n_step = word.target;
                SQ_DISPATCH: n_step = accept ? dispatch(i_in.func) : S_IDLE;
                SQ_EMIT:     n_step = emit ? S_IDLE : S_OUT;
                default:     n_step = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== src/hedf_checker.sv =====
// port-level checker for the half-edge flip core, bound to the top level
module hedf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input hedf_pkg::t_out_item o_out
);
    import hedf_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // a refused command returns a zero read value
    a_rv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.status == ST_DONE || o_out.read_value == '0))
        else $error("nonzero read_value on a refused command");

    // one command at a time: a taken beat closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a beat was taken");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result beat changed");

endmodule

bind half_edge_diagonal_flip_core hedf_checker u_hedf_checker (.*);
